// ----- design/cve_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cve_pkg
// Shared types and constants of the column value encoder.
// ----------------------------------------------------------------------------
package cve_pkg;

  localparam int DictDepthDefault = 16;

  localparam logic [1:0] RegValueBytes = 2'd0;
  localparam logic [1:0] RegCodingMode = 2'd1;
  localparam logic [1:0] RegNullable   = 2'd2;
  localparam logic [1:0] RegBigEndian  = 2'd3;

  localparam logic OpAppend = 1'b0;
  localparam logic OpFinish = 1'b1;

  localparam logic [1:0] BaseRaw    = 2'd0;
  localparam logic [1:0] BaseVarint = 2'd1;
  localparam logic [1:0] BaseDelta  = 2'd2;
  localparam logic [1:0] BaseDict   = 2'd3;

  // emission steps of one item
  localparam logic [1:0] StepPresence = 2'd0;
  localparam logic [1:0] StepValue    = 2'd1;
  localparam logic [1:0] StepCount    = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [63:0] value;
    logic        is_null;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       dict_new;
    logic       dict_full;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SEARCH_WAIT,
    S_CODE,
    S_NULLB,
    S_VAL,
    S_FIN
  } state_t;

  // emit request from sequencer to byte emitter
  typedef struct packed {
    logic        start;
    logic        varint;   // 1 varint, 0 raw
    logic        status;   // one status-only result, no byte
    logic [63:0] data;
    logic [3:0]  nbytes;   // raw byte count
    logic        is_final; // last piece of this item
  } emit_req_t;

endpackage

`default_nettype wire

// ----- design/column_value_encoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// column_value_encoder_top
// Column encoder: null byte, raw/varint/delta/dictionary coding, run-length.
// ----------------------------------------------------------------------------
// Null entries and finish go straight to emission; appends pass the dictionary
//   search, entry by entry in dictionary mode, and coding before their first result.
// Throughput: one item at a time; input stalls until the last piece is handed to the
//   emitter; the emitter sends one byte per transfer while the output is not stalled.
// Reset clears the sequencer state, run and dictionary count; memory contents stay undefined.
module column_value_encoder_top
  import cve_pkg::*;
#(
  parameter int DICT_DEPTH = DictDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire in_item_t    in_item,
  input  wire logic        in_valid,
  output logic             in_stall,
  output out_item_t        out_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(DICT_DEPTH);
  localparam int CW = $clog2(DICT_DEPTH + 1);

  logic [3:0] value_bytes;
  logic [2:0] coding_mode;
  logic       nullable, big_endian_data;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      value_bytes <= 4'd8;
      coding_mode <= 3'd0;
      nullable <= 1'b0;
      big_endian_data <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegValueBytes: value_bytes <= pwdata[3:0];
        RegCodingMode: coding_mode <= pwdata[2:0];
        RegNullable:   nullable <= pwdata[0];
        RegBigEndian:  big_endian_data <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegValueBytes: prdata = {28'd0, value_bytes};
      RegCodingMode: prdata = {29'd0, coding_mode};
      RegNullable:   prdata = {31'd0, nullable};
      RegBigEndian:  prdata = {31'd0, big_endian_data};
      default:       prdata = 32'd0;
    endcase
  end

  logic [3:0] nb;
  assign nb = (value_bytes == 4'd0) ? 4'd1 : (value_bytes > 4'd8) ? 4'd8 : value_bytes;
  logic       rle;
  logic [1:0] base;
  assign rle = coding_mode[2];
  assign base = coding_mode[1:0];

  // dictionary memory; an entry is searched only items after it was written
  logic [63:0] dict_mem [DICT_DEPTH];
  logic [63:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0] wr_data;
  always_ff @(posedge clk) begin
    if (wr_en) dict_mem[wr_addr] <= wr_data;
    rd_data <= dict_mem[rd_addr];
  end

  state_t state, state_next;
  in_item_t item;
  logic [63:0] rv, wv, previous_value, run_value, run_count;
  logic [CW-1:0] dict_count, idx, idx_inc;
  logic [1:0] step;
  logic fnew, ffull;
  logic ebusy;
  logic can_issue;
  logic flush_run;
  emit_req_t req, piece;

  // byte assembly of the column value
  logic [63:0] rv_c;
  always_comb begin
    int n;
    n = int'(nb);
    rv_c = 64'd0;
    for (int i = 0; i < 8; i++) begin
      if (i < n) begin
        if (big_endian_data) rv_c[8*(n-1-i) +: 8] = item.value[8*i +: 8];
        else rv_c[8*i +: 8] = item.value[8*i +: 8];
      end
    end
  end

  logic [63:0] dlt;
  assign dlt = rv - previous_value;

  assign in_stall = (state != S_IDLE);
  assign idx_inc = idx + CW'(1);
  // the next entry is fetched while the current one is compared
  assign rd_addr = (state == S_SEARCH_WAIT) ? idx_inc[AW-1:0] : idx[AW-1:0];
  assign wr_en = (state == S_CODE) && (base == BaseDict) && (idx == dict_count)
                 && (dict_count < CW'(DICT_DEPTH));
  assign wr_addr = dict_count[AW-1:0];
  assign wr_data = rv;
  assign can_issue = !ebusy && !req.start;
  // a coded value that differs from the run value ends the open run
  assign flush_run = (run_count != 64'd0) && (wv != run_value);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_SEARCH;
      S_SEARCH: begin
        if (item.operation == OpFinish) state_next = S_FIN;
        else if (nullable && item.is_null) state_next = S_NULLB;
        else if (base == BaseDict && dict_count != '0) state_next = S_SEARCH_WAIT;
        else state_next = S_CODE;
      end
      S_SEARCH_WAIT: if (rd_data == rv || idx_inc >= dict_count) state_next = S_CODE;
      S_CODE: state_next = S_VAL;
      S_VAL: begin
        case (step)
          StepPresence: ;
          StepValue: begin
            if (!(rle && flush_run) && (piece.start || (rle && nullable)))
              state_next = S_IDLE;
          end
          default: if (piece.start) state_next = S_IDLE;
        endcase
      end
      S_NULLB: if (piece.start) state_next = S_IDLE;
      S_FIN: begin
        if (!rle || run_count == 64'd0) state_next = S_IDLE;
        else if (step == StepCount && piece.start) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // next piece handed to the byte emitter
  always_comb begin
    piece = '{start: 1'b0, varint: 1'b0, status: 1'b0, data: 64'd0, nbytes: nb,
              is_final: 1'b0};
    case (state)
      S_VAL: begin
        case (step)
          StepPresence: if (nullable) begin
            piece.start = 1'b1;
            piece.data = 64'd1;
            piece.nbytes = 4'd1;
            piece.is_final = rle && !flush_run;
          end
          StepValue: begin
            if (!rle) begin
              piece.start = 1'b1;
              piece.varint = (base != BaseRaw);
              piece.data = wv;
              piece.is_final = 1'b1;
            end else if (flush_run) begin
              piece.start = 1'b1;
              piece.varint = (base != BaseRaw);
              piece.data = run_value;
            end else if (!nullable) begin
              // nothing to send: status-only result
              piece.start = 1'b1;
              piece.status = 1'b1;
              piece.is_final = 1'b1;
            end
          end
          default: begin
            piece.start = 1'b1;
            piece.varint = 1'b1;
            piece.data = run_count;
            piece.is_final = 1'b1;
          end
        endcase
      end
      S_NULLB: begin
        piece.start = 1'b1;
        piece.nbytes = 4'd1;
        piece.is_final = 1'b1;
      end
      S_FIN: if (rle && run_count != 64'd0) begin
        piece.start = 1'b1;
        if (step == StepCount) begin
          piece.varint = 1'b1;
          piece.data = run_count;
          piece.is_final = 1'b1;
        end else begin
          piece.varint = (base != BaseRaw);
          piece.data = run_value;
        end
      end
      default: ;
    endcase
    piece.start = piece.start && can_issue;
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      previous_value <= 64'd0;
      run_value <= 64'd0;
      run_count <= 64'd0;
      dict_count <= '0;
      idx <= '0;
      step <= StepPresence;
      req <= '0;
      fnew <= 1'b0;
      ffull <= 1'b0;
    end else begin
      state <= state_next;
      req <= piece;
      case (state)
        S_IDLE: if (in_valid) begin
          item <= in_item;
          idx <= '0;
          fnew <= 1'b0;
          ffull <= 1'b0;
        end
        S_SEARCH: begin
          rv <= rv_c;
          step <= StepPresence;
        end
        // a miss on the last entry leaves idx at dict_count
        S_SEARCH_WAIT: if (rd_data != rv) idx <= idx_inc;
        S_CODE: begin
          if (base == BaseDelta) begin
            wv <= (dlt << 1) ^ {64{dlt[63]}};
            previous_value <= rv;
          end else if (base == BaseDict) begin
            wv <= {{(64-CW){1'b0}}, idx};
            if (wr_en) begin
              dict_count <= dict_count + CW'(1);
              fnew <= 1'b1;
            end else if (idx == dict_count) begin
              ffull <= 1'b1;
            end
          end else begin
            wv <= rv;
          end
        end
        S_VAL: begin
          case (step)
            StepPresence: if (!nullable || piece.start) step <= StepValue;
            StepValue: begin
              if (rle && flush_run) begin
                if (piece.start) step <= StepCount;
              end else if (rle && (nullable || piece.start)) begin
                if (run_count == 64'd0) begin
                  run_value <= wv;
                  run_count <= 64'd1;
                end else if (run_count != '1) run_count <= run_count + 64'd1;
              end
            end
            default: if (piece.start) begin
              run_value <= wv;
              run_count <= 64'd1;
            end
          endcase
        end
        S_FIN: if (piece.start) begin
          if (step == StepCount) run_count <= 64'd0;
          else step <= StepCount;
        end
        default: ;
      endcase
    end
  end

  cve_emit u_emit (
    .clk(clk), .rst(rst), .req(req), .dnew(fnew), .dfull(ffull),
    .busy(ebusy), .out_item(out_item), .out_valid(out_valid), .out_stall(out_stall)
  );

endmodule

`default_nettype wire

// ----- design/cve_emit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cve_emit
// Byte emitter: shifts out one raw, varint or status-only piece, one byte per transfer.
// ----------------------------------------------------------------------------
module cve_emit
  import cve_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire emit_req_t req,
  input  wire logic      dnew,
  input  wire logic      dfull,
  output logic           busy,
  output out_item_t      out_item,
  output logic           out_valid,
  input  wire logic      out_stall
);

  logic        active;
  logic        vmode;
  logic        status;
  logic [63:0] data;
  logic [3:0]  left;
  logic        fin;
  logic        fnew, ffull;
  logic        more;
  logic [7:0]  b;

  assign busy = active || out_valid;

  always_comb begin
    if (status) begin
      more = 1'b0;
      b = 8'd0;
    end else if (vmode) begin
      more = (data[63:7] != 57'd0);
      b = {more, data[6:0]};
    end else begin
      more = (left > 4'd1);
      b = data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      out_valid <= 1'b0;
    end else if (req.start) begin
      active <= 1'b1;
      vmode <= req.varint;
      status <= req.status;
      data <= req.data;
      left <= req.nbytes;
      fin <= req.is_final;
      fnew <= dnew;
      ffull <= dfull;
    end else if (active && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
      out_item <= '{out_byte: b, byte_valid: !status, last: fin && !more,
                    dict_new: fnew, dict_full: ffull};
      data <= vmode ? (data >> 7) : (data >> 8);
      left <= left - 4'd1;
      if (!more) active <= 1'b0;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- test/column_value_encoder_top_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// column_value_encoder_top_tb
// Self-checking bench for the column value encoder: directed and random
// column values across all coding modes and a range of widths, checked byte by byte
// against an internal encoder model, with bursty input and random stalls.
// ----------------------------------------------------------------------------
module column_value_encoder_top_tb;
  import cve_pkg::*;

  localparam int DictSize = 16;
  localparam int CycleLimit = 400000;

  logic clk;
  logic rst;
  in_item_t in_item;
  logic in_valid;
  logic in_stall;
  out_item_t out_item;
  logic out_valid;
  logic out_stall;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  column_value_encoder_top #(.DICT_DEPTH(DictSize)) DUT (
    .clk(clk), .rst(rst),
    .in_item(in_item), .in_valid(in_valid), .in_stall(in_stall),
    .out_item(out_item), .out_valid(out_valid), .out_stall(out_stall),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // model configuration and state
  logic [3:0]  m_width;
  logic [2:0]  m_mode;
  logic        m_nullable;
  logic        m_big_endian;
  logic [63:0] m_prev;
  logic [63:0] m_run_value;
  logic [63:0] m_run_count;
  logic [63:0] m_dict [DictSize];
  int          m_dict_count;

  in_item_t  pending_items[$];
  out_item_t expected_bytes[$];
  logic [7:0] enc_buf[$];
  int   errors = 0;
  int   cycles = 0;
  bit   hold_off = 1'b0;
  bit   pause_sender = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void put_varint(logic [63:0] v);
    while (v >= 64'h80) begin
      enc_buf.insert(enc_buf.size(), {1'b1, v[6:0]});
      v = v >> 7;
    end
    enc_buf.insert(enc_buf.size(), v[7:0]);
  endfunction

  function automatic void put_raw(logic [63:0] v, int nb);
    for (int i = 0; i < nb; i++) enc_buf.insert(enc_buf.size(), v[8*i +: 8]);
  endfunction

  function automatic void flush_run(int nb);
    if (m_mode[1:0] == BaseRaw) put_raw(m_run_value, nb);
    else put_varint(m_run_value);
    put_varint(m_run_count);
  endfunction

  // compute the bytes one input transfer produces and queue them
  function automatic void encode_item(in_item_t it);
    int nb;
    bit rle;
    logic [1:0] base;
    bit fnew, ffull, done, found;
    logic [63:0] rv, wv, d;
    out_item_t r;
    nb = (m_width == 0) ? 1 : (m_width > 8) ? 8 : int'(m_width);
    rle = m_mode[2];
    base = m_mode[1:0];
    fnew = 0;
    ffull = 0;
    enc_buf.delete();
    if (it.operation == OpFinish) begin
      if (!rle || m_run_count == 0) return;
      flush_run(nb);
      m_run_count = 0;
    end else begin
      done = 0;
      if (m_nullable) begin
        if (it.is_null) begin
          enc_buf.insert(enc_buf.size(), 8'd0);
          done = 1;
        end else enc_buf.insert(enc_buf.size(), 8'd1);
      end
      if (!done) begin
        rv = 0;
        for (int i = 0; i < nb; i++) begin
          if (m_big_endian) rv[8*(nb-1-i) +: 8] = it.value[8*i +: 8];
          else rv[8*i +: 8] = it.value[8*i +: 8];
        end
        wv = rv;
        if (base == BaseDelta) begin
          d = rv - m_prev;
          wv = (d << 1) ^ (d[63] ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0);
          m_prev = rv;
        end else if (base == BaseDict) begin
          found = 0;
          for (int j = 0; j < m_dict_count; j++) begin
            if (!found && m_dict[j] == rv) begin
              wv = 64'(j);
              found = 1;
            end
          end
          if (!found) begin
            if (m_dict_count < DictSize) begin
              m_dict[m_dict_count] = rv;
              wv = 64'(m_dict_count);
              m_dict_count++;
              fnew = 1;
            end else begin
              wv = 64'(DictSize);
              ffull = 1;
            end
          end
        end
        if (rle) begin
          if (m_run_count == 0) begin
            m_run_value = wv;
            m_run_count = 1;
          end else if (wv != m_run_value) begin
            flush_run(nb);
            m_run_value = wv;
            m_run_count = 1;
          end else if (m_run_count != '1) begin
            m_run_count++;
          end
        end else if (base == BaseRaw) put_raw(wv, nb);
        else put_varint(wv);
      end
    end
    if (enc_buf.size() == 0) begin
      r = '{out_byte: 8'd0, byte_valid: 1'b0, last: 1'b1, dict_new: fnew, dict_full: ffull};
      expected_bytes.insert(expected_bytes.size(), r);
      return;
    end
    foreach (enc_buf[k]) begin
      r = '{out_byte: enc_buf[k], byte_valid: 1'b1, last: (k == enc_buf.size() - 1),
            dict_new: fnew, dict_full: ffull};
      expected_bytes.insert(expected_bytes.size(), r);
    end
  endfunction

  // driver: bursts and gaps; model advances on each accepted transfer
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) encode_item(in_item);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pause_sender || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(12, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20, 0);
          end else burst_left <= burst_left - 1;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_mode;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected output, expected none, actual %p", $realtime, out_item);
          errors <= errors + 1;
        end else if (out_item !== expected_bytes[0]) begin
          $display("%0t: mismatch, expected %p, actual %p", $realtime,
                   expected_bytes[0], out_item);
          errors <= errors + 1;
          void'(expected_bytes.pop_front());
        end else void'(expected_bytes.pop_front());
      end
      if ($urandom_range(63, 0) == 0) stall_mode <= $urandom_range(2, 0);
      if (hold_off) out_stall <= 1'b1;
      else case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3, 0) == 0);
        default: out_stall <= ($urandom_range(3, 0) != 0);
      endcase
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegValueBytes: m_width = data[3:0];
      RegCodingMode: m_mode = data[2:0];
      RegNullable:   m_nullable = data[0];
      default:       m_big_endian = data[0];
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (DictSize + 8) @(posedge clk);
  endtask

  task automatic configure(int w, int md, int nl, int be);
    drain();
    apb_write(RegValueBytes, w);
    apb_write(RegCodingMode, md);
    apb_write(RegNullable, nl);
    apb_write(RegBigEndian, be);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void add_item(logic op, logic [63:0] v, logic nul);
    in_item_t it;
    it.operation = op;
    it.value = v;
    it.is_null = nul;
    pending_items.insert(pending_items.size(), it);
  endfunction

  // values biased to repeat so runs and dictionary hits happen
  logic [63:0] pool[8];
  function automatic logic [63:0] pick_value();
    case ($urandom_range(3, 0))
      0: return rand64();
      1: return 64'($urandom_range(300, 0));
      default: return pool[$urandom_range(7, 0)];
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    m_width = 4'd8; m_mode = 3'd0; m_nullable = 0; m_big_endian = 0;
    m_prev = 0; m_run_value = 0; m_run_count = 0; m_dict_count = 0;
    foreach (m_dict[i]) m_dict[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, several modes, null and finish cases
    add_item(OpAppend, 64'd0, 1'b0);
    add_item(OpAppend, '1, 1'b1);
    add_item(OpFinish, 64'd0, 1'b0);
    configure(8, 1, 1, 0);
    add_item(OpAppend, '1, 1'b0);
    add_item(OpAppend, 64'h7F, 1'b0);
    add_item(OpAppend, 64'h80, 1'b1);
    configure(8, 2, 0, 1);
    add_item(OpAppend, 64'h0100_0000_0000_0000, 1'b1);
    add_item(OpAppend, 64'd0, 1'b0);
    add_item(OpAppend, '1, 1'b0);
    configure(0, 3, 0, 0);
    for (int i = 0; i < 18; i++) add_item(OpAppend, 64'(i), 1'b0);
    configure(15, 7, 1, 0);
    add_item(OpAppend, 64'd5, 1'b0);
    add_item(OpAppend, 64'd5, 1'b0);
    add_item(OpAppend, 64'd5, 1'b1);
    add_item(OpAppend, 64'd9, 1'b0);
    add_item(OpFinish, 64'd0, 1'b0);
    add_item(OpFinish, 64'd0, 1'b0);
    configure(3, 4, 0, 1);
    add_item(OpAppend, '1, 1'b0);
    add_item(OpAppend, '1, 1'b0);
    add_item(OpFinish, 64'd0, 1'b0);

    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      foreach (pool[i]) pool[i] = (i < 4) ? rand64() : 64'($urandom_range(255, 0));
      configure((ph == 0) ? 1 : (ph == 1) ? 8 : $urandom_range(15, 0),
                ph % 8, $urandom_range(1, 0), $urandom_range(1, 0));
      for (int i = 0; i < 27; i++) begin
        if ($urandom_range(9, 0) == 0) add_item(OpFinish, rand64(), $urandom_range(1, 0));
        else add_item(OpAppend, pick_value(), ($urandom_range(7, 0) == 0));
      end
      add_item(OpFinish, 64'd0, 1'b0);
      if (ph == 4) begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      if (ph == 9) begin
        pause_sender <= 1'b1;
        @(posedge clk);
        while (in_valid || expected_bytes.size() != 0) @(posedge clk);
        pause_sender <= 1'b0;
      end
    end

    drain();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
